>>> hw/rtl/bole_pkg.sv
package bole_pkg;

    // request codes
    localparam logic [2:0] OP_INS_HEAD = 3'd0;
    localparam logic [2:0] OP_INS_TAIL = 3'd1;
    localparam logic [2:0] OP_INS_POS  = 3'd2;
    localparam logic [2:0] OP_REM_HEAD = 3'd3;
    localparam logic [2:0] OP_REM_TAIL = 3'd4;
    localparam logic [2:0] OP_REM_POS  = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;

    localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DRAIN,
        ST_FINAL
    } bole_state_t;

endpackage

>>> hw/rtl/bole_ram.sv
module bole_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [bole_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [bole_pkg::DATA_W-1:0] rd_data
);
    import bole_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/bounded_ordered_list_engine_top.sv
// bounded ordered list engine
// keeps an ordered list of up to CAPACITY signed 32-bit entries in one
// synchronous memory; position 0 is the head.
// request channel: opcode, value and position are taken at a rising edge
// where start is high and busy is low. busy stays high while the request
// is worked on.
// result channel: done is high for exactly one cycle with removed_value,
// status and entry_count; the receiver cannot stall, so the word must be
// taken in that cycle.
// steps: a request that reads no entries goes from accept to the finishing
// step, then done; one that reads entries passes a shift step and a drain
// step first. in the shift step the single memory read port fetches one
// entry a cycle and each entry but the removed one is written back one place
// up or down. a head or positional request reads (length - position)
// entries, the removed one included; a tail remove reads one and a tail
// insert none. a new request may be started in the cycle done is shown.
// reset: the list becomes empty at once; no clearing pass is needed, as
// only entries below the length are ever read.
module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        opcode,
    input  logic signed [bole_pkg::DATA_W-1:0] value,
    input  logic [bole_pkg::POS_W-1:0]        position,
    output logic                              done,
    output logic signed [bole_pkg::DATA_W-1:0] removed_value,
    output logic [1:0]                        status,
    output logic [bole_pkg::CNT_W-1:0]        entry_count
);
    import bole_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam int EW = (LW > CNT_W) ? LW : CNT_W;
    localparam logic [LW-1:0] CAP_LEN = LW'(CAPACITY);

    bole_state_t state_reg, state_next;
    logic [LW-1:0]     len_reg, len_next;
    logic              is_rem_reg, is_rem_next;
    logic [AW-1:0]     p_reg, p_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [1:0]        stat_reg, stat_next;
    logic              pend_reg, pend_next;
    logic              cap_reg, cap_next;
    logic [AW-1:0]     dest_reg, dest_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] out_val_reg, out_val_next;
    logic [1:0]        out_stat_reg, out_stat_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic [CW-1:0]     pos_ext;
    logic [CW-1:0]     len_ext;
    logic [AW-1:0]     last_idx;
    logic [EW-1:0]     cnt_wide;

    bole_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pos_ext  = CW'(position);
    assign len_ext  = CW'(len_reg);
    assign last_idx = AW'(len_reg - LW'(1));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        is_rem_reg   <= is_rem_next;
        p_reg        <= p_next;
        cur_reg      <= cur_next;
        val_reg      <= val_next;
        stat_reg     <= stat_next;
        cap_reg      <= cap_next;
        dest_reg     <= dest_next;
        rem_reg      <= rem_next;
        out_val_reg  <= out_val_next;
        out_stat_reg <= out_stat_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        is_rem_next   = is_rem_reg;
        p_next        = p_reg;
        cur_next      = cur_reg;
        val_next      = val_reg;
        stat_next     = stat_reg;
        pend_next     = 1'b0;
        cap_next      = 1'b0;
        dest_next     = dest_reg;
        rem_next      = rem_reg;
        done_next     = 1'b0;
        out_val_next  = out_val_reg;
        out_stat_next = out_stat_reg;
        out_cnt_next  = out_cnt_reg;
        wr_en         = 1'b0;
        wr_addr       = dest_reg;
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        cnt_wide      = EW'(len_reg);

        // write back or capture the word fetched last cycle
        if (pend_reg)
        begin
            if (cap_reg)
            begin
                rem_next = rd_data;
            end
            else
            begin
                wr_en = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    val_next    = value;
                    rem_next    = NEG_ONE;
                    stat_next   = STAT_OK;
                    is_rem_next = 1'b0;
                    p_next      = '0;
                    cur_next    = last_idx;
                    state_next  = ST_FINAL;
                    priority if (opcode == OP_INS_HEAD || opcode == OP_INS_TAIL
                                 || opcode == OP_INS_POS)
                    begin
                        priority if (len_reg >= CAP_LEN)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else if (opcode == OP_INS_POS && pos_ext >= len_ext)
                        begin
                            stat_next = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            if (opcode == OP_INS_TAIL)
                            begin
                                p_next = AW'(len_reg);
                            end
                            else if (opcode == OP_INS_POS)
                            begin
                                p_next = AW'(pos_ext);
                            end
                            // entries to move up unless appending
                            if (!(opcode == OP_INS_TAIL || len_reg == '0))
                            begin
                                state_next = ST_SHIFT;
                            end
                        end
                    end
                    else if (opcode == OP_REM_HEAD || opcode == OP_REM_TAIL
                             || opcode == OP_REM_POS)
                    begin
                        is_rem_next = 1'b1;
                        priority if (len_reg == '0)
                        begin
                            stat_next = STAT_NOT_FOUND;
                        end
                        else if (opcode == OP_REM_POS && pos_ext >= len_ext)
                        begin
                            stat_next = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            if (opcode == OP_REM_TAIL)
                            begin
                                p_next   = last_idx;
                                cur_next = last_idx;
                            end
                            else if (opcode == OP_REM_POS)
                            begin
                                p_next   = AW'(pos_ext);
                                cur_next = AW'(pos_ext);
                            end
                            else
                            begin
                                cur_next = '0;
                            end
                            state_next = ST_SHIFT;
                        end
                    end
                    else
                    begin
                        stat_next = STAT_NOT_FOUND;
                    end
                end
            end

            ST_SHIFT:
            begin
                // one fetch a cycle, written back one place over, or captured if removed, next cycle
                rd_en     = 1'b1;
                pend_next = 1'b1;
                if (is_rem_reg)
                begin
                    cap_next  = (cur_reg == p_reg);
                    dest_next = cur_reg - AW'(1);
                    cur_next  = cur_reg + AW'(1);
                    if (cur_reg == last_idx)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    dest_next = cur_reg + AW'(1);
                    cur_next  = cur_reg - AW'(1);
                    if (cur_reg == p_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_FINAL;
            end

            ST_FINAL:
            begin
                if (stat_reg == STAT_OK)
                begin
                    if (is_rem_reg)
                    begin
                        len_next = len_reg - LW'(1);
                    end
                    else
                    begin
                        len_next = len_reg + LW'(1);
                        wr_en    = 1'b1;
                        wr_addr  = p_reg;
                        wr_data  = val_reg;
                    end
                end
                cnt_wide      = EW'(len_next);
                done_next     = 1'b1;
                out_val_next  = rem_reg;
                out_stat_next = stat_reg;
                out_cnt_next  = cnt_wide[CNT_W-1:0];
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign removed_value = out_val_reg;
    assign status        = out_stat_reg;
    assign entry_count   = out_cnt_reg;

    // checks
    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINAL))
        else $error("result word without a finishing step");

    a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_FULL) |-> (len_reg == CAP_LEN))
        else $error("full reported below capacity");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP_LEN)
        else $error("length beyond capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

    a_fail_neg_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (removed_value == NEG_ONE))
        else $error("failed request returned a value");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bole_pkg::*;

    localparam int CAP       = 64;
    localparam int N_RANDOM  = 1550;
    localparam int CYC_LIMIT = 1000000;

    // directed row: expect_given marks rows whose result is typed in
    typedef struct {
        logic [2:0]        op;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  pos;
        bit                expect_given;
        logic [DATA_W-1:0] exp_removed;
        logic [1:0]        exp_status;
        logic [CNT_W-1:0]  exp_count;
    } row_t;

    typedef struct packed {
        logic [DATA_W-1:0] removed;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
    } list_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     done;
    logic signed [DATA_W-1:0] removed_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;

    // own copy of the list
    logic [DATA_W-1:0] shadow_list[$];
    list_word_t        pending_words[$];
    int                error_count;
    int                cycle_count;
    int                result_count;

    bounded_ordered_list_engine_top #(.CAPACITY(CAP)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .value(value), .position(position), .done(done),
        .removed_value(removed_value), .status(status), .entry_count(entry_count)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // apply one request to the shadow list, return the expected word
    function automatic list_word_t apply_request(logic [2:0] op, logic [DATA_W-1:0] v,
                                                 logic [POS_W-1:0] p);
        list_word_t w;
        int         len;
        len       = shadow_list.size();
        w.removed = NEG_ONE;
        w.status  = STAT_OK;
        case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
            begin
                if (len >= CAP)
                    w.status = STAT_FULL;
                else if (op == OP_INS_HEAD)
                    shadow_list.push_front(v);
                else if (op == OP_INS_TAIL)
                    shadow_list.push_back(v);
                else if (p >= len)
                    w.status = STAT_NOT_FOUND;
                else
                    shadow_list.insert(p, v);
            end
            OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS:
            begin
                if (len == 0)
                    w.status = STAT_NOT_FOUND;
                else if (op == OP_REM_HEAD)
                    w.removed = shadow_list.pop_front();
                else if (op == OP_REM_TAIL)
                    w.removed = shadow_list.pop_back();
                else if (p >= len)
                    w.status = STAT_NOT_FOUND;
                else
                begin
                    w.removed = shadow_list[p];
                    shadow_list.delete(p);
                end
            end
            default:
                w.status = STAT_NOT_FOUND;
        endcase
        w.count = CNT_W'(shadow_list.size());
        return w;
    endfunction

    // issue one word and wait for acceptance; start stays high on return
    task automatic send_word(logic [2:0] op, logic [DATA_W-1:0] v, logic [POS_W-1:0] p,
                             bit given, list_word_t typed);
        list_word_t w;
        start    <= 1'b1;
        opcode   <= op;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        w = apply_request(op, v, p);
        if (given && w !== typed)
        begin
            $display("%0t: table row disagrees with prediction exp %h/%0d/%0d got %h/%0d/%0d",
                     $time, typed.removed, typed.status, typed.count,
                     w.removed, w.status, w.count);
            error_count++;
        end
        pending_words.push_back(given ? typed : w);
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            list_word_t e;
            result_count++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word removed=%h status=%0d count=%0d",
                         $time, removed_value, status, entry_count);
                error_count++;
            end
            else
            begin
                e = pending_words.pop_front();
                if (removed_value !== e.removed)
                begin
                    $display("%0t: removed_value exp %h got %h", $time, e.removed, removed_value);
                    error_count++;
                end
                if (status !== e.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, status);
                    error_count++;
                end
                if (entry_count !== e.count)
                begin
                    $display("%0t: entry_count exp %0d got %0d", $time, e.count, entry_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // random request, mostly well formed with a bias to fill and drain
    task automatic send_random(int fill_bias);
        logic [2:0]        op;
        logic [DATA_W-1:0] v;
        logic [POS_W-1:0]  p;
        int                len;
        int                r;
        list_word_t        dummy;
        len = shadow_list.size();
        r   = $urandom_range(99);
        if (r < 2)
            op = 3'($urandom_range(7, 6));
        else if ($urandom_range(99) < fill_bias)
            op = 3'($urandom_range(OP_INS_POS, OP_INS_HEAD));
        else
            op = 3'($urandom_range(OP_REM_POS, OP_REM_HEAD));
        case ($urandom_range(3))
            0: v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: v = $urandom;
        endcase
        if (len > 0 && $urandom_range(9) < 8)
            p = POS_W'($urandom_range(len - 1));
        else
            p = POS_W'($urandom);
        dummy = '{default: '0};
        send_word(op, v, p, 1'b0, dummy);
    endtask

    initial
    begin
        row_t       rows[$];
        list_word_t typed;
        int         burst;
        int         bias;
        int         wait_cyc;

        error_count  = 0;
        cycle_count  = 0;
        result_count = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        opcode   = OP_INS_HEAD;
        value    = '0;
        position = '0;

        // directed table
        rows = '{
            '{OP_REM_HEAD, 32'h0, 6'd0, 1, NEG_ONE, STAT_NOT_FOUND, 7'd0},
            '{OP_REM_TAIL, 32'h0, 6'd0, 1, NEG_ONE, STAT_NOT_FOUND, 7'd0},
            '{OP_REM_POS, 32'h0, 6'd0, 1, NEG_ONE, STAT_NOT_FOUND, 7'd0},
            '{OP_INS_POS, 32'h5, 6'd0, 1, NEG_ONE, STAT_NOT_FOUND, 7'd0},
            '{3'd6, 32'h0, 6'd0, 1, NEG_ONE, STAT_NOT_FOUND, 7'd0},
            '{3'd7, 32'hffff_ffff, 6'd63, 1, NEG_ONE, STAT_NOT_FOUND, 7'd0},
            '{OP_INS_TAIL, 32'h7fff_ffff, 6'd0, 1, NEG_ONE, STAT_OK, 7'd1},
            '{OP_INS_HEAD, 32'h8000_0000, 6'd0, 1, NEG_ONE, STAT_OK, 7'd2},
            '{OP_INS_POS, 32'h0000_0001, 6'd0, 1, NEG_ONE, STAT_OK, 7'd3},
            '{OP_INS_POS, 32'hffff_fffe, 6'd2, 0, '0, '0, '0},
            '{OP_INS_POS, 32'h1234_5678, 6'd4, 1, NEG_ONE, STAT_NOT_FOUND, 7'd4},
            '{OP_REM_POS, 32'h0, 6'd63, 1, NEG_ONE, STAT_NOT_FOUND, 7'd4},
            '{OP_REM_POS, 32'h0, 6'd2, 0, '0, '0, '0},
            '{OP_REM_HEAD, 32'h0, 6'd0, 1, 32'h0000_0001, STAT_OK, 7'd2},
            '{OP_REM_TAIL, 32'h0, 6'd0, 1, 32'h7fff_ffff, STAT_OK, 7'd1},
            '{OP_REM_POS, 32'h0, 6'd0, 1, 32'h8000_0000, STAT_OK, 7'd0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            typed = '{rows[i].exp_removed, rows[i].exp_status, rows[i].exp_count};
            send_word(rows[i].op, rows[i].val, rows[i].pos, rows[i].expect_given, typed);
        end

        // fill to capacity, overflow, then remove one entry at the far end
        while (shadow_list.size() < CAP)
            send_random(100);
        typed = '{NEG_ONE, STAT_FULL, 7'(CAP)};
        send_word(OP_INS_HEAD, 32'h5555_aaaa, 6'd0, 1'b1, typed);
        send_word(OP_INS_POS, 32'haaaa_5555, 6'd63, 1'b1, typed);
        send_word(OP_REM_POS, 32'h0, 6'd63, 1'b0, typed);

        // hold off until every word is back
        start <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);

        // random bursts with gaps; bias swings between filling and draining
        bias = 70;
        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(40, 1);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
            begin
                if (shadow_list.size() >= CAP - 2)
                    bias = 25;
                else if (shadow_list.size() <= 1)
                    bias = 75;
                send_random(bias);
            end
            if ($urandom_range(3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(12, 1)) @(negedge clk);
            end
        end

        start <= 1'b0;
        @(negedge clk);
        wait_cyc = 0;
        while (pending_words.size() != 0 && wait_cyc < 20000)
        begin
            @(negedge clk);
            wait_cyc++;
        end
        repeat (CAP + 10) @(negedge clk);

        if (error_count == 0 && pending_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> bounded_ordered_list_engine_top.f
hw/rtl/bole_pkg.sv
hw/rtl/bole_ram.sv
hw/rtl/bounded_ordered_list_engine_top.sv
bench/testbench.sv
